// File: design/text_line_numbering_filter_core_macros.svh
// Assertion macros for the line numbering filter.
// Used by modules that declare clk and arst_n; no other dependencies.
`ifndef TEXT_LINE_NUMBERING_FILTER_CORE_MACROS_SVH
`define TEXT_LINE_NUMBERING_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TLNF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLNF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/tlnf_pkg.sv
// Shared types, constants and helpers for the line numbering filter.
// No dependencies.
`default_nettype none

package tlnf_pkg;

	localparam int NUM_DIGITS  = 6;
	localparam int CNT_W       = 4 * NUM_DIGITS;
	localparam int SLOT_TAB    = NUM_DIGITS;
	localparam int SLOT_DOLLAR = NUM_DIGITS + 1;
	localparam int SLOT_B0     = NUM_DIGITS + 2;
	localparam int SLOT_B1     = NUM_DIGITS + 3;
	localparam int NUM_SLOTS   = NUM_DIGITS + 4;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_NUMBER_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd4;

	localparam logic [1:0] MODE_EVERY = 2'd1;

	localparam logic [7:0] CH_NL       = 8'h0A;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_CARET    = 8'h5E;
	localparam logic [7:0] CH_I        = 8'h49;
	localparam logic [7:0] CH_DOLLAR   = 8'h24;
	localparam logic [7:0] CH_PREV_RST = 8'h61;
	localparam logic [7:0] CTRL_MAX    = 8'd31;
	localparam logic [7:0] CARET_OFS   = 8'd64;

	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	typedef struct packed {
		logic [NUM_SLOTS-1:0] mask;
		logic [CNT_W-1:0]     digits;
		logic [7:0]           body0;
		logic [7:0]           body1;
	} job_t;

	function automatic logic [CNT_W-1:0] bcd_inc(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		logic carry;
		logic full;
		r = c;
		carry = 1'b1;
		full = 1'b1;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (c[4*i +: 4] != 4'd9) full = 1'b0;
		end
		if (!full) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				if (carry) begin
					if (r[4*i +: 4] >= 4'd9) begin
						r[4*i +: 4] = 4'd0;
					end else begin
						r[4*i +: 4] = r[4*i +: 4] + 4'd1;
						carry = 1'b0;
					end
				end
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: design/tlnf_front.sv
// Front end: configuration registers, line state, per-byte classification.
// Depends on tlnf_pkg.
`default_nettype none

module tlnf_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [7:0]                      in_byte,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tlnf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tlnf_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                                 push_valid,
	input  wire logic                            push_ready,
	output tlnf_pkg::job_t                       push_job
);

	logic [1:0] number_mode_q;
	logic       show_ends_q;
	logic       show_tabs_q;
	logic       show_np_q;
	logic       squeeze_q;

	logic [tlnf_pkg::CNT_W-1:0] counter_q;
	logic [7:0]                 prev_byte_q;
	logic                       prev_blank_q;
	logic                       first_q;

	logic accept;
	logic nonblank_mode;
	logic every_mode;
	logic is_nl;
	logic prev_nl;
	logic squeeze;
	logic want;
	logic prefix;
	logic dollar;
	logic two_byte;
	logic [7:0] body0;
	logic [7:0] body1;

	assign cfg_ready = 1'b1;
	assign in_ready  = push_ready;
	assign accept    = in_valid && push_ready;

	assign nonblank_mode = number_mode_q[1];
	assign every_mode    = (number_mode_q == tlnf_pkg::MODE_EVERY);
	assign is_nl         = (in_byte == tlnf_pkg::CH_NL);
	assign prev_nl       = (prev_byte_q == tlnf_pkg::CH_NL);
	assign squeeze       = prev_blank_q && is_nl && squeeze_q;
	assign want          = prev_nl && ((nonblank_mode && !is_nl) || every_mode);
	assign prefix        = ((nonblank_mode || every_mode) && first_q) || (!squeeze && want);
	assign dollar        = !squeeze && is_nl && show_ends_q;

	always_comb begin
		two_byte = 1'b0;
		body0    = in_byte;
		body1    = tlnf_pkg::CH_I;
		if (show_tabs_q && in_byte == tlnf_pkg::CH_TAB) begin
			two_byte = 1'b1;
			body0    = tlnf_pkg::CH_CARET;
		end else if (show_np_q && in_byte <= tlnf_pkg::CTRL_MAX && !is_nl
				&& in_byte != tlnf_pkg::CH_TAB) begin
			two_byte = 1'b1;
			body0    = tlnf_pkg::CH_CARET;
			body1    = in_byte + tlnf_pkg::CARET_OFS;
		end
	end

	always_comb begin
		push_job        = '0;
		push_job.digits = counter_q;
		push_job.body0  = body0;
		push_job.body1  = body1;
		push_job.mask[tlnf_pkg::SLOT_TAB:0]     = {(tlnf_pkg::SLOT_TAB + 1){prefix}};
		push_job.mask[tlnf_pkg::SLOT_DOLLAR]    = dollar;
		push_job.mask[tlnf_pkg::SLOT_B0]        = !squeeze;
		push_job.mask[tlnf_pkg::SLOT_B1]        = !squeeze && two_byte;
	end

	assign push_valid = in_valid && (prefix || !squeeze);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_mode_q <= '0;
			show_ends_q   <= 1'b0;
			show_tabs_q   <= 1'b0;
			show_np_q     <= 1'b0;
			squeeze_q     <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tlnf_pkg::REG_NUMBER_MODE:      number_mode_q <= cfg_data[1:0];
				tlnf_pkg::REG_SHOW_ENDS:        show_ends_q   <= cfg_data[0];
				tlnf_pkg::REG_SHOW_TABS:        show_tabs_q   <= cfg_data[0];
				tlnf_pkg::REG_SHOW_NONPRINTING: show_np_q     <= cfg_data[0];
				tlnf_pkg::REG_SQUEEZE_BLANK:    squeeze_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q    <= tlnf_pkg::CNT_ONE;
			prev_byte_q  <= tlnf_pkg::CH_PREV_RST;
			prev_blank_q <= 1'b0;
			first_q      <= 1'b1;
		end else if (accept) begin
			if (prefix) begin
				counter_q <= tlnf_pkg::bcd_inc(counter_q);
				first_q   <= 1'b0;
			end
			if (!squeeze) begin
				prev_blank_q <= prev_nl && is_nl;
				prev_byte_q  <= in_byte;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/tlnf_queue.sv
// Short job queue between the front end and the serializer.
// Depends on tlnf_pkg.
`default_nettype none

module tlnf_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire tlnf_pkg::job_t push_job,
	output logic                q_valid,
	input  wire logic           q_pop,
	output tlnf_pkg::job_t      q_job
);

	tlnf_pkg::job_t entries_q [tlnf_pkg::QDEPTH];

	logic [tlnf_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [tlnf_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [tlnf_pkg::QPTR_W:0]   count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != (tlnf_pkg::QPTR_W + 1)'(tlnf_pkg::QDEPTH));
	assign q_valid    = (count_q != '0);
	assign q_job      = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + (tlnf_pkg::QPTR_W)'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + (tlnf_pkg::QPTR_W)'(1);
			if (push && !pop) begin
				count_q <= count_q + (tlnf_pkg::QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (tlnf_pkg::QPTR_W + 1)'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: design/tlnf_back.sv
// Serializer: walks the slots of the head job and drives the output register.
// Depends on tlnf_pkg and the assertion macro header.
`default_nettype none
`include "text_line_numbering_filter_core_macros.svh"

module tlnf_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire tlnf_pkg::job_t q_job,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          out_byte,
	output logic                last_of_run
);

	logic [tlnf_pkg::NUM_SLOTS-1:0] cons_q;
	logic [tlnf_pkg::NUM_SLOTS-1:0] active;
	logic [tlnf_pkg::NUM_SLOTS-1:0] pick;
	logic [tlnf_pkg::NUM_SLOTS-1:0] rest;
	logic [7:0] slot_byte [tlnf_pkg::NUM_SLOTS];
	logic [7:0] sel_byte;
	logic       last;
	logic       load;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;

	assign active = q_job.mask & ~cons_q;
	assign pick   = active & (~active + (tlnf_pkg::NUM_SLOTS)'(1));
	assign rest   = active & ~pick;
	assign last   = (rest == '0);
	assign load   = q_valid && (!out_valid_q || out_ready);
	assign q_pop  = load && last;

	always_comb begin
		logic       leading;
		logic [3:0] d;
		leading = 1'b1;
		for (int k = 0; k < tlnf_pkg::NUM_DIGITS; k++) begin
			d = q_job.digits[4*(tlnf_pkg::NUM_DIGITS-1-k) +: 4];
			if (d != 4'd0 || k == tlnf_pkg::NUM_DIGITS - 1) leading = 1'b0;
			if (leading) begin
				slot_byte[k] = tlnf_pkg::CH_SPACE;
			end else begin
				slot_byte[k] = tlnf_pkg::CH_ZERO + {4'd0, (d > 4'd9) ? 4'd9 : d};
			end
		end
		slot_byte[tlnf_pkg::SLOT_TAB]    = tlnf_pkg::CH_TAB;
		slot_byte[tlnf_pkg::SLOT_DOLLAR] = tlnf_pkg::CH_DOLLAR;
		slot_byte[tlnf_pkg::SLOT_B0]     = q_job.body0;
		slot_byte[tlnf_pkg::SLOT_B1]     = q_job.body1;
	end

	always_comb begin
		sel_byte = '0;
		for (int i = 0; i < tlnf_pkg::NUM_SLOTS; i++) begin
			sel_byte = sel_byte | (slot_byte[i] & {8{pick[i]}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cons_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cons_q      <= last ? '0 : (cons_q | pick);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= sel_byte;
			last_q     <= last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

	`TLNF_ASSERT_IMPL(a_head_nonempty, q_valid, q_job.mask != '0, "empty job in queue")
	`TLNF_ASSERT_IMPL(a_cons_subset, q_valid, (cons_q & ~q_job.mask) == '0, "stray slot")
	`TLNF_ASSERT_IMPL(a_cons_idle, !q_valid, cons_q == '0, "slots consumed with no job")
	`TLNF_ASSERT_NEXT(a_pop_clears, q_pop, cons_q == '0, "slot state not cleared on pop")

endmodule

`default_nettype wire

// File: design/text_line_numbering_filter_core.sv
// Line numbering text filter, top level.
// Instantiates tlnf_front, tlnf_queue and tlnf_back; depends on tlnf_pkg.
//
// Input channel in_valid/in_ready/in_byte takes one raw text byte per beat.
// Output channel out_valid/out_ready/out_byte/last_of_run gives the formatted
// bytes in order; last_of_run marks the final beat caused by one input byte.
// A squeezed newline with no pending first-line prefix gives no output beat.
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the
// registers: 0 number_mode, 1 show_ends, 2 show_tabs, 3 show_nonprinting,
// 4 squeeze_blank. cfg_ready is always high; write only while idle.
// Each byte's job is registered in the job queue; its beats then leave through the output register.
// Throughput: one output beat per cycle while out_ready is high; a byte gives up
// to 9 output beats with a line number prefix. The front end accepts a byte
// every cycle while the two-entry job queue has room.
// Reset clears configuration to zero, the line counter to one and empties
// the queue and output register. When out_ready is low, the output beat
// holds, the queue fills, then in_ready drops.
`default_nettype none

module text_line_numbering_filter_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [7:0]                      in_byte,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [7:0]                           out_byte,
	output logic                                 last_of_run,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tlnf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tlnf_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic           push_valid;
	logic           push_ready;
	tlnf_pkg::job_t push_job;
	logic           q_valid;
	logic           q_pop;
	tlnf_pkg::job_t q_job;

	tlnf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	tlnf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_job      (q_job)
	);

	tlnf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_job       (q_job),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

// File: verif/text_line_numbering_filter_core_test.sv
// Self-checking testbench for text_line_numbering_filter_core: directed table, then phases of
// random text under varying register settings, with random stalls on both channels.
// Depends on tlnf_pkg and the core RTL only.
module text_line_numbering_filter_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] MODE_NONE     = 2'd0;
	localparam logic [1:0] MODE_NONBLANK = 2'd2;
	localparam logic [1:0] MODE_BOTH     = 2'd3;
	localparam logic [tlnf_pkg::CNT_W-1:0] ALL_NINES = {tlnf_pkg::NUM_DIGITS{4'h9}};
	localparam int         DRAIN_CYCLES  = 12;
	localparam int         HOLD_CYCLES   = 300;
	localparam int         PHASES        = 7;
	localparam int         PHASE_BYTES   = 40;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_last;
	} beat_t;

	typedef struct packed {
		logic                           is_reg;
		logic                           rnd;
		logic [tlnf_pkg::CFG_IDX_W-1:0] idx;
		logic [7:0]                     val;
		logic [3:0]                     n_typed;
		logic [71:0]                    typed;
	} row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	logic [7:0]                      in_byte;
	logic                            out_valid;
	logic                            out_ready;
	logic [7:0]                      out_byte;
	logic                            last_of_run;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [tlnf_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tlnf_pkg::CFG_DATA_W-1:0] cfg_data;

	logic [1:0]                 num_mode;
	bit                         ends_on, tabs_on, ctrl_on, squeeze_on;
	logic [tlnf_pkg::CNT_W-1:0] line_bcd;
	logic [7:0]                 prev_ch;
	bit                         prev_blank, first_pending;

	logic [7:0] run_chars[$];
	beat_t      pending_beats[$];
	row_t       directed[$];

	bit steady;
	bit hold_req;
	int bytes_sent, beats_checked, reg_writes, error_count;

	text_line_numbering_filter_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last_of_run(last_of_run),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function void emit_number();
		logic [3:0] d;
		bit lead;
		bit carry;
		lead = 1'b1;
		for (int i = tlnf_pkg::NUM_DIGITS - 1; i >= 0; i--) begin
			d = line_bcd[4*i +: 4];
			if (d != 4'd0 || i == 0) lead = 1'b0;
			run_chars.push_back(lead ? tlnf_pkg::CH_SPACE : tlnf_pkg::CH_ZERO + {4'h0, d});
		end
		run_chars.push_back(tlnf_pkg::CH_TAB);
		if (line_bcd != ALL_NINES) begin
			carry = 1'b1;
			for (int i = 0; i < tlnf_pkg::NUM_DIGITS; i++) begin
				if (carry) begin
					if (line_bcd[4*i +: 4] == 4'd9) begin
						line_bcd[4*i +: 4] = 4'd0;
					end else begin
						line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
						carry = 1'b0;
					end
				end
			end
		end
		first_pending = 1'b0;
	endfunction

	function void format_byte(input logic [7:0] b);
		bit nonblank_mode, every_mode, prev_nl;
		nonblank_mode = num_mode[1];
		every_mode = num_mode == tlnf_pkg::MODE_EVERY;
		prev_nl = prev_ch == tlnf_pkg::CH_NL;
		run_chars.delete();
		if ((nonblank_mode || every_mode) && first_pending) emit_number();
		if (!(prev_blank && b == tlnf_pkg::CH_NL && squeeze_on)) begin
			prev_blank = prev_nl && b == tlnf_pkg::CH_NL;
			if (prev_nl && ((nonblank_mode && b != tlnf_pkg::CH_NL) || every_mode) &&
					run_chars.size() == 0)
				emit_number();
			if (b == tlnf_pkg::CH_NL && ends_on) run_chars.push_back(tlnf_pkg::CH_DOLLAR);
			if (tabs_on && b == tlnf_pkg::CH_TAB) begin
				run_chars.push_back(tlnf_pkg::CH_CARET);
				run_chars.push_back(tlnf_pkg::CH_I);
			end else if (ctrl_on && b <= tlnf_pkg::CTRL_MAX && b != tlnf_pkg::CH_NL &&
					b != tlnf_pkg::CH_TAB) begin
				run_chars.push_back(tlnf_pkg::CH_CARET);
				run_chars.push_back(b + tlnf_pkg::CARET_OFS);
			end else begin
				run_chars.push_back(b);
			end
			prev_ch = b;
		end
	endfunction

	function row_t text_row(input logic [7:0] b, input int n, input logic [71:0] exp_chars);
		return '{is_reg: 1'b0, rnd: 1'b0, idx: '0, val: b, n_typed: n[3:0], typed: exp_chars};
	endfunction

	function row_t reg_row(input logic [tlnf_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] v,
			input bit rnd);
		return '{is_reg: 1'b1, rnd: rnd, idx: idx, val: v, n_typed: 4'd0, typed: '0};
	endfunction

	function logic [7:0] text_char();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25) return tlnf_pkg::CH_NL;
		if (pick < 33) return tlnf_pkg::CH_TAB;
		if (pick < 45) return 8'($urandom_range(0, 31));
		if (pick < 55) return 8'($urandom_range(127, 255));
		return 8'($urandom_range(32, 126));
	endfunction

	task automatic write_reg(input logic [tlnf_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] v);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_beats.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			tlnf_pkg::REG_NUMBER_MODE:      num_mode = v[1:0];
			tlnf_pkg::REG_SHOW_ENDS:        ends_on = v[0];
			tlnf_pkg::REG_SHOW_TABS:        tabs_on = v[0];
			tlnf_pkg::REG_SHOW_NONPRINTING: ctrl_on = v[0];
			tlnf_pkg::REG_SQUEEZE_BLANK:    squeeze_on = v[0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic send_byte(input logic [7:0] b, input int n_typed, input logic [71:0] typed);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (!in_ready);
		format_byte(b);
		if (n_typed > 0) begin
			for (int k = 0; k < n_typed; k++)
				pending_beats.push_back('{ch: typed[8*(n_typed-1-k) +: 8],
					is_last: k == n_typed - 1});
		end else begin
			foreach (run_chars[k])
				pending_beats.push_back('{ch: run_chars[k], is_last: k == run_chars.size() - 1});
		end
		bytes_sent++;
	endtask

	initial begin
		in_valid = 1'b0;
		in_byte = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		steady = 1'b0;
		hold_req = 1'b0;
		num_mode = MODE_NONE;
		{ends_on, tabs_on, ctrl_on, squeeze_on} = '0;
		line_bcd = tlnf_pkg::CNT_ONE;
		prev_ch = tlnf_pkg::CH_PREV_RST;
		prev_blank = 1'b0;
		first_pending = 1'b1;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		directed = {
			text_row(8'h41, 1, "A"),
			text_row(8'h00, 1, 72'h00),
			text_row(8'hFF, 1, 72'hFF),
			text_row(tlnf_pkg::CH_NL, 1, "\n"),
			text_row(tlnf_pkg::CH_NL, 1, "\n"),
			reg_row(tlnf_pkg::REG_NUMBER_MODE, 8'(tlnf_pkg::MODE_EVERY), 1'b0),
			reg_row(tlnf_pkg::REG_SQUEEZE_BLANK, 8'd1, 1'b1),
			text_row(tlnf_pkg::CH_NL, 0, '0),
			text_row(8'h78, 0, '0),
			reg_row(tlnf_pkg::REG_SHOW_ENDS, 8'd1, 1'b0),
			reg_row(tlnf_pkg::REG_SHOW_TABS, 8'd1, 1'b0),
			reg_row(tlnf_pkg::REG_SHOW_NONPRINTING, 8'd1, 1'b0),
			reg_row(tlnf_pkg::REG_SQUEEZE_BLANK, 8'd1, 1'b0),
			text_row(tlnf_pkg::CH_NL, 0, '0),
			text_row(tlnf_pkg::CH_NL, 0, '0),
			text_row(tlnf_pkg::CH_NL, 0, '0),
			text_row(tlnf_pkg::CH_TAB, 0, '0),
			text_row(8'h01, 0, '0),
			text_row(tlnf_pkg::CTRL_MAX, 0, '0),
			text_row(8'h7F, 0, '0),
			text_row(tlnf_pkg::CH_SPACE, 0, '0),
			text_row(tlnf_pkg::CH_NL, 0, '0),
			reg_row(tlnf_pkg::REG_NUMBER_MODE, 8'(MODE_NONBLANK), 1'b0),
			reg_row(tlnf_pkg::REG_SHOW_TABS, 8'd0, 1'b0),
			reg_row(tlnf_pkg::REG_SQUEEZE_BLANK, 8'd0, 1'b0),
			text_row(tlnf_pkg::CH_NL, 0, '0),
			text_row(tlnf_pkg::CH_NL, 0, '0),
			text_row(tlnf_pkg::CH_TAB, 0, '0),
			text_row(8'h00, 0, '0),
			text_row(tlnf_pkg::CH_NL, 0, '0),
			reg_row(tlnf_pkg::REG_NUMBER_MODE, 8'(MODE_BOTH), 1'b0),
			reg_row(tlnf_pkg::REG_SHOW_NONPRINTING, 8'd0, 1'b0),
			reg_row(tlnf_pkg::REG_SHOW_ENDS, 8'd0, 1'b0),
			text_row(8'h1B, 0, '0),
			text_row(tlnf_pkg::CH_NL, 0, '0),
			text_row(tlnf_pkg::CH_NL, 0, '0),
			text_row(8'h7A, 0, '0)
		};

		foreach (directed[i]) begin
			if (directed[i].is_reg)
				write_reg(directed[i].idx, directed[i].rnd ?
					8'($urandom_range(0, directed[i].val)) : directed[i].val);
			else
				send_byte(directed[i].val, directed[i].n_typed, directed[i].typed);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					write_reg(tlnf_pkg::REG_NUMBER_MODE, 8'(MODE_NONE));
					write_reg(tlnf_pkg::REG_SHOW_ENDS, 8'd0);
					write_reg(tlnf_pkg::REG_SHOW_TABS, 8'd0);
					write_reg(tlnf_pkg::REG_SHOW_NONPRINTING, 8'd0);
					write_reg(tlnf_pkg::REG_SQUEEZE_BLANK, 8'd0);
				end
				1, 2: begin
					write_reg(tlnf_pkg::REG_NUMBER_MODE,
						8'(phase == 1 ? MODE_NONBLANK : tlnf_pkg::MODE_EVERY));
					write_reg(tlnf_pkg::REG_SHOW_ENDS, 8'd1);
					write_reg(tlnf_pkg::REG_SHOW_TABS, 8'd1);
					write_reg(tlnf_pkg::REG_SHOW_NONPRINTING, 8'd1);
					write_reg(tlnf_pkg::REG_SQUEEZE_BLANK, 8'd1);
				end
				default: begin
					write_reg(tlnf_pkg::REG_NUMBER_MODE, 8'($urandom_range(0, 3)));
					write_reg(tlnf_pkg::REG_SHOW_ENDS, 8'($urandom_range(0, 1)));
					write_reg(tlnf_pkg::REG_SHOW_TABS, 8'($urandom_range(0, 1)));
					write_reg(tlnf_pkg::REG_SHOW_NONPRINTING, 8'($urandom_range(0, 1)));
					write_reg(tlnf_pkg::REG_SQUEEZE_BLANK, 8'($urandom_range(0, 1)));
				end
			endcase
			steady = phase == 4;
			if (phase == 3) hold_req = 1'b1;
			repeat (PHASE_BYTES) send_byte(text_char(), 0, '0);
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending_beats.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d text bytes into %0d checked output beats across %0d register writes",
			bytes_sent, beats_checked, reg_writes);
		$display("including all numbering modes, caret rendering, squeezing and a %0d-cycle hold-off",
			HOLD_CYCLES);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Receiver: random stalls per beat, one long hold-off on request.
	initial begin
		int stall;
		out_ready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				stall = steady ? 0 : $urandom_range(0, 5);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		beat_t want;
		if (arst_n && out_valid && out_ready) begin
			beats_checked++;
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat, actual out_byte=%h last_of_run=%b",
					$time, out_byte, last_of_run);
				error_count++;
			end else begin
				want = pending_beats.pop_front();
				if (out_byte !== want.ch) begin
					$display("%0t: out_byte mismatch, expected %h actual %h",
						$time, want.ch, out_byte);
					error_count++;
				end
				if (last_of_run !== want.is_last) begin
					$display("%0t: last_of_run mismatch, expected %b actual %b",
						$time, want.is_last, last_of_run);
					error_count++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d beats still expected", pending_beats.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: text_line_numbering_filter_core.f
+incdir+design
design/tlnf_pkg.sv
design/tlnf_front.sv
design/tlnf_queue.sv
design/tlnf_back.sv
design/text_line_numbering_filter_core.sv
verif/text_line_numbering_filter_core_test.sv
